### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL of the quad collision unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SQC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SQC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/sqc_pkg.sv
// ----------------------------------------------------------------------------
// sqc_pkg
// Shared widths, types and control structures of the quad collision unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sqc_pkg;

   // Coordinate width inside the datapath and the widths derived from it.
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;

   // Fixed port field widths.
   localparam int FIELD_BITS = 16;
   localparam int SEP_BITS   = 35;
   localparam int EDGE_BITS  = 17;
   localparam int IDX_BITS   = 2;

   // Vertex store geometry: two quads of four vertices.
   localparam int NUM_VERTS = 8;
   localparam int ADDR_BITS = $clog2(NUM_VERTS);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic [ADDR_BITS-1:0]         addr_type;
   typedef logic [IDX_BITS-1:0]          idx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   // Write port of the vertex store.
   typedef struct packed {
      logic       en;
      addr_type   addr;
      vertex_type data;
   } wr_port_type;

   // Dual read request of the vertex store.
   typedef struct packed {
      logic     en;
      addr_type addr0;
      addr_type addr1;
   } rd_req_type;

   // Datapath control issued by the sequencer each cycle.
   typedef struct packed {
      logic    issue;
      logic    first;
      logic    last;
      logic    side;
      idx_type edge_idx;
      logic    normal_ld;
      logic    out_ld;
   } dp_ctl_type;

endpackage

`default_nettype wire

### src/sqc_vertex_ram.sv
// ----------------------------------------------------------------------------
// sqc_vertex_ram
// Eight-entry vertex store with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sqc_vertex_ram (
   input  logic                 clock,
   input  sqc_pkg::wr_port_type wr_port,
   input  sqc_pkg::rd_req_type  rd_req,
   output sqc_pkg::vertex_type  rd_data0,
   output sqc_pkg::vertex_type  rd_data1
);
   import sqc_pkg::*;

   vertex_type vertex_mem_ff [NUM_VERTS];
   vertex_type rd0_ff;
   vertex_type rd1_ff;

   // Vertex writes from the load transactions.
   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         vertex_mem_ff[wr_port.addr] <= wr_port.data;
      end
   end

   // Both read ports deliver their data in the cycle after the request.
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd0_ff <= vertex_mem_ff[rd_req.addr0];
         rd1_ff <= vertex_mem_ff[rd_req.addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

`default_nettype wire

### src/sqc_sequencer.sv
// ----------------------------------------------------------------------------
// sqc_sequencer
// Microcode sequencer: a step counter walks a small control ROM, with edge and
// vertex pair loop counters that drive the store addresses and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sqc_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  sqc_pkg::idx_type    best_b_idx,
   output logic                busy,
   output sqc_pkg::rd_req_type rd_req,
   output sqc_pkg::dp_ctl_type dp_ctl
);
   import sqc_pkg::*;

   typedef enum logic [1:0] {
      ADDR_EDGE,
      ADDR_PAIR,
      ADDR_FINAL
   } addr_sel_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_PAIR_LOOP,
      JMP_EDGE_LOOP,
      JMP_DONE
   } jump_type;

   typedef logic [3:0] step_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      logic         rd_en;
      logic         normal_ld;
      logic         issue;
      logic         edge_inc;
      logic         out_ld;
      jump_type     jump;
      step_type     target;
   } ucode_type;

   // Program step addresses.
   localparam step_type STEP_EDGE_RD   = 4'd0;
   localparam step_type STEP_EDGE_LD   = 4'd1;
   localparam step_type STEP_PAIR      = 4'd2;
   localparam step_type STEP_EDGE_NEXT = 4'd3;
   localparam step_type STEP_DRAIN0    = 4'd4;
   localparam step_type STEP_DRAIN1    = 4'd5;
   localparam step_type STEP_DRAIN2    = 4'd6;
   localparam step_type STEP_FINAL_RD  = 4'd7;
   localparam step_type STEP_FINISH    = 4'd8;

   localparam logic [3:0] PAIR_LAST = 4'd15;
   localparam logic [2:0] EDGE_LAST = 3'd7;

   // Control ROM: one word per program step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_EDGE_RD: begin
            w.addr_sel = ADDR_EDGE;
            w.rd_en    = 1'b1;
         end
         STEP_EDGE_LD: begin
            w.normal_ld = 1'b1;
         end
         STEP_PAIR: begin
            w.addr_sel = ADDR_PAIR;
            w.rd_en    = 1'b1;
            w.issue    = 1'b1;
            w.jump     = JMP_PAIR_LOOP;
            w.target   = STEP_PAIR;
         end
         STEP_EDGE_NEXT: begin
            w.edge_inc = 1'b1;
            w.jump     = JMP_EDGE_LOOP;
            w.target   = STEP_EDGE_RD;
         end
         STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2: begin
            w.jump = JMP_NONE;
         end
         STEP_FINAL_RD: begin
            w.addr_sel = ADDR_FINAL;
            w.rd_en    = 1'b1;
         end
         STEP_FINISH: begin
            w.out_ld = 1'b1;
            w.jump   = JMP_DONE;
         end
         default: begin
            w.jump = JMP_DONE;
         end
      endcase
      return w;
   endfunction

   logic       running_ff, running_in;
   step_type   step_ff, step_in;
   logic [2:0] edge_cnt_ff, edge_cnt_in;
   logic [3:0] pair_cnt_ff, pair_cnt_in;
   ucode_type  word;
   logic       side;
   idx_type    edge_i;
   idx_type    vert_j;
   idx_type    vert_k;

   assign word   = ucode_rom(step_ff);
   assign side   = edge_cnt_ff[2];
   assign edge_i = edge_cnt_ff[1:0];
   assign vert_j = pair_cnt_ff[3:2];
   assign vert_k = pair_cnt_ff[1:0];

   // Next step, loop counters and program end.
   always_comb begin
      running_in  = running_ff;
      step_in     = step_ff;
      edge_cnt_in = edge_cnt_ff;
      pair_cnt_in = pair_cnt_ff;
      if (go) begin
         running_in  = 1'b1;
         step_in     = STEP_EDGE_RD;
         edge_cnt_in = '0;
         pair_cnt_in = '0;
      end else if (running_ff) begin
         if (word.issue) begin
            pair_cnt_in = pair_cnt_ff + 4'd1;
         end
         if (word.edge_inc) begin
            edge_cnt_in = edge_cnt_ff + 3'd1;
         end
         unique case (word.jump)
            JMP_NONE: begin
               step_in = step_ff + 4'd1;
            end
            JMP_PAIR_LOOP: begin
               step_in = (pair_cnt_ff != PAIR_LAST) ? word.target : step_ff + 4'd1;
            end
            JMP_EDGE_LOOP: begin
               step_in = (edge_cnt_ff != EDGE_LAST) ? word.target : step_ff + 4'd1;
            end
            JMP_DONE: begin
               running_in = 1'b0;
               step_in    = STEP_EDGE_RD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         step_ff     <= STEP_EDGE_RD;
         edge_cnt_ff <= '0;
         pair_cnt_ff <= '0;
      end else begin
         running_ff  <= running_in;
         step_ff     <= step_in;
         edge_cnt_ff <= edge_cnt_in;
         pair_cnt_ff <= pair_cnt_in;
      end
   end

   // Store addresses: edge endpoints, own/other vertex pair, or B's best edge.
   always_comb begin
      rd_req.en = running_ff & word.rd_en;
      unique case (word.addr_sel)
         ADDR_EDGE: begin
            rd_req.addr0 = {side, edge_i};
            rd_req.addr1 = {side, edge_i + 2'd1};
         end
         ADDR_PAIR: begin
            rd_req.addr0 = {side, vert_j};
            rd_req.addr1 = {~side, vert_k};
         end
         ADDR_FINAL: begin
            rd_req.addr0 = {1'b1, best_b_idx};
            rd_req.addr1 = {1'b1, best_b_idx + 2'd1};
         end
         default: begin
            rd_req.addr0 = '0;
            rd_req.addr1 = '0;
         end
      endcase
   end

   // Datapath control and tags that travel with each vertex pair.
   always_comb begin
      dp_ctl.issue     = running_ff & word.issue;
      dp_ctl.first     = (pair_cnt_ff == '0);
      dp_ctl.last      = (pair_cnt_ff == PAIR_LAST);
      dp_ctl.side      = side;
      dp_ctl.edge_idx  = edge_i;
      dp_ctl.normal_ld = running_ff & word.normal_ld;
      dp_ctl.out_ld    = running_ff & word.out_ld;
   end

   assign busy = running_ff;

endmodule

`default_nettype wire

### src/sqc_datapath.sv
// ----------------------------------------------------------------------------
// sqc_datapath
// Shared projection unit: vertex difference, two products, sum and running
// minimum per edge, maximum per quad, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sqc_pkg::dp_ctl_type           dp_ctl,
   input  sqc_pkg::vertex_type           rd_data0,
   input  sqc_pkg::vertex_type           rd_data1,
   output sqc_pkg::idx_type              best_b_idx,
   output logic                          rsp_valid,
   output logic                          rsp_collide,
   output logic signed [sqc_pkg::SEP_BITS-1:0]  rsp_separation_a,
   output logic signed [sqc_pkg::SEP_BITS-1:0]  rsp_separation_b,
   output logic signed [sqc_pkg::EDGE_BITS-1:0] rsp_edge_b_x,
   output logic signed [sqc_pkg::EDGE_BITS-1:0] rsp_edge_b_y,
   output logic [sqc_pkg::IDX_BITS-1:0]         rsp_edge_b_index
);
   import sqc_pkg::*;

   typedef struct packed {
      logic    valid;
      logic    first;
      logic    last;
      logic    side;
      idx_type edge_idx;
   } tag_type;

   tag_type  tag_a_ff, tag_b_ff, tag_c_ff;
   tag_type  done_ff;
   diff_type sub_x, sub_y;
   diff_type diff_x_ff, diff_y_ff;
   diff_type normal_x_ff, normal_y_ff;
   prod_type prod_x_in, prod_y_in;
   prod_type prod_x_ff, prod_y_ff;
   sum_type  sum_in;
   sum_type  lowest_ff;
   sum_type  best_a_ff, best_b_ff;
   sum_type  best_cur;
   idx_type  best_b_idx_ff;
   logic     replace;

   logic                        rsp_valid_ff;
   logic                        rsp_collide_ff;
   logic signed [SEP_BITS-1:0]  rsp_sep_a_ff, rsp_sep_b_ff;
   logic signed [EDGE_BITS-1:0] rsp_edge_x_ff, rsp_edge_y_ff;
   idx_type                     rsp_edge_idx_ff;

   // One subtractor on the read data serves pair differences and edges alike.
   assign sub_x = DIFF_BITS'(rd_data0.x) - DIFF_BITS'(rd_data1.x);
   assign sub_y = DIFF_BITS'(rd_data0.y) - DIFF_BITS'(rd_data1.y);

   // Tag pipeline: the valid bits are reset, the payload rides along with the pair.
   always_ff @(posedge clock) begin
      tag_a_ff.first    <= dp_ctl.first;
      tag_a_ff.last     <= dp_ctl.last;
      tag_a_ff.side     <= dp_ctl.side;
      tag_a_ff.edge_idx <= dp_ctl.edge_idx;
      tag_b_ff.first    <= tag_a_ff.first;
      tag_b_ff.last     <= tag_a_ff.last;
      tag_b_ff.side     <= tag_a_ff.side;
      tag_b_ff.edge_idx <= tag_a_ff.edge_idx;
      tag_c_ff.first    <= tag_b_ff.first;
      tag_c_ff.last     <= tag_b_ff.last;
      tag_c_ff.side     <= tag_b_ff.side;
      tag_c_ff.edge_idx <= tag_b_ff.edge_idx;
      done_ff.first     <= tag_c_ff.first;
      done_ff.last      <= tag_c_ff.last;
      done_ff.side      <= tag_c_ff.side;
      done_ff.edge_idx  <= tag_c_ff.edge_idx;
      if (reset) begin
         tag_a_ff.valid <= 1'b0;
         tag_b_ff.valid <= 1'b0;
         tag_c_ff.valid <= 1'b0;
         done_ff.valid  <= 1'b0;
      end else begin
         tag_a_ff.valid <= dp_ctl.issue;
         tag_b_ff.valid <= tag_a_ff.valid;
         tag_c_ff.valid <= tag_b_ff.valid;
         done_ff.valid  <= tag_c_ff.valid & tag_c_ff.last;
      end
   end

   // Edge normal (ey, -ex) latched from the edge endpoint read.
   always_ff @(posedge clock) begin
      if (dp_ctl.normal_ld) begin
         normal_x_ff <= sub_y;
         normal_y_ff <= -sub_x;
      end
   end

   // Stage A: own vertex minus other vertex.
   always_ff @(posedge clock) begin
      if (tag_a_ff.valid) begin
         diff_x_ff <= sub_x;
         diff_y_ff <= sub_y;
      end
   end

   // Stage B: the two products of the dot product.
   assign prod_x_in = diff_x_ff * normal_x_ff;
   assign prod_y_in = diff_y_ff * normal_y_ff;

   always_ff @(posedge clock) begin
      if (tag_b_ff.valid) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
   end

   // Stage C: projection sum and running minimum over the sixteen pairs.
   assign sum_in = SUM_BITS'(prod_x_ff) + SUM_BITS'(prod_y_ff);

   always_ff @(posedge clock) begin
      if (tag_c_ff.valid && (tag_c_ff.first || (sum_in < lowest_ff))) begin
         lowest_ff <= sum_in;
      end
   end

   // Stage D: keep the largest edge minimum per quad; the first edge wins ties.
   assign best_cur = done_ff.side ? best_b_ff : best_a_ff;
   assign replace  = done_ff.valid && ((done_ff.edge_idx == '0) || (lowest_ff > best_cur));

   always_ff @(posedge clock) begin
      if (replace) begin
         if (done_ff.side) begin
            best_b_ff     <= lowest_ff;
            best_b_idx_ff <= done_ff.edge_idx;
         end else begin
            best_a_ff     <= lowest_ff;
         end
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_ctl.out_ld;
      end
   end

   // Result payload; the edge comes from the re-read of B's best edge.
   always_ff @(posedge clock) begin
      if (dp_ctl.out_ld) begin
         rsp_collide_ff  <= (best_a_ff[SUM_BITS-1] || (best_a_ff == '0)) &&
                            (best_b_ff[SUM_BITS-1] || (best_b_ff == '0));
         rsp_sep_a_ff    <= SEP_BITS'(best_a_ff);
         rsp_sep_b_ff    <= SEP_BITS'(best_b_ff);
         rsp_edge_x_ff   <= EDGE_BITS'(sub_x);
         rsp_edge_y_ff   <= EDGE_BITS'(sub_y);
         rsp_edge_idx_ff <= best_b_idx_ff;
      end
   end

   assign best_b_idx       = best_b_idx_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_collide      = rsp_collide_ff;
   assign rsp_separation_a = rsp_sep_a_ff;
   assign rsp_separation_b = rsp_sep_b_ff;
   assign rsp_edge_b_x     = rsp_edge_x_ff;
   assign rsp_edge_b_y     = rsp_edge_y_ff;
   assign rsp_edge_b_index = rsp_edge_idx_ff;

endmodule

`default_nettype wire

### src/sat_quad_collision_unit.sv
// ----------------------------------------------------------------------------
// sat_quad_collision_unit
// The eighth vertex taken starts the program; the result strobe ends it.
// No vertex is taken while busy. The shared projection unit takes one vertex pair
// per cycle in each edge's pair loop, pausing between edges for the edge reads.
// Reset clears the load count, sequencer and strobe; the vertex store is not cleared.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sat_quad_collision_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [sqc_pkg::FIELD_BITS-1:0]  req_vertex_x,
   input  logic signed [sqc_pkg::FIELD_BITS-1:0]  req_vertex_y,
   output logic                                   rsp_valid,
   output logic                                   rsp_collide,
   output logic signed [sqc_pkg::SEP_BITS-1:0]    rsp_separation_a,
   output logic signed [sqc_pkg::SEP_BITS-1:0]    rsp_separation_b,
   output logic signed [sqc_pkg::EDGE_BITS-1:0]   rsp_edge_b_x,
   output logic signed [sqc_pkg::EDGE_BITS-1:0]   rsp_edge_b_y,
   output logic [sqc_pkg::IDX_BITS-1:0]           rsp_edge_b_index
);
   import sqc_pkg::*;

   localparam addr_type LOAD_LAST = ADDR_BITS'(NUM_VERTS - 1);

   logic        req_accept;
   logic        go;
   addr_type    load_count_ff, load_count_in;
   wr_port_type wr_port;
   rd_req_type  rd_req;
   dp_ctl_type  dp_ctl;
   vertex_type  rd_data0, rd_data1;
   idx_type     best_b_idx;

   // Load transactions fill the store in order; the eighth starts the program.
   assign req_accept    = start & ~busy;
   assign go            = req_accept && (load_count_ff == LOAD_LAST);
   assign load_count_in = req_accept ? load_count_ff + addr_type'(1) : load_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   always_comb begin
      wr_port.en     = req_accept;
      wr_port.addr   = load_count_ff;
      wr_port.data.x = coord_type'(req_vertex_x);
      wr_port.data.y = coord_type'(req_vertex_y);
   end

   sqc_vertex_ram u_ram (
      .clock    (clock),
      .wr_port  (wr_port),
      .rd_req   (rd_req),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   sqc_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .best_b_idx (best_b_idx),
      .busy       (busy),
      .rd_req     (rd_req),
      .dp_ctl     (dp_ctl)
   );

   sqc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_ctl           (dp_ctl),
      .rd_data0         (rd_data0),
      .rd_data1         (rd_data1),
      .best_b_idx       (best_b_idx),
      .rsp_valid        (rsp_valid),
      .rsp_collide      (rsp_collide),
      .rsp_separation_a (rsp_separation_a),
      .rsp_separation_b (rsp_separation_b),
      .rsp_edge_b_x     (rsp_edge_b_x),
      .rsp_edge_b_y     (rsp_edge_b_y),
      .rsp_edge_b_index (rsp_edge_b_index)
   );

   // The eighth vertex starts the program, and no load happens while it runs.
   `SQC_ASSERT_NEXT(a_go_sets_busy, clock, reset, go, busy, "program did not start")
   `SQC_ASSERT_IMPL(a_no_load_while_busy, clock, reset, busy, load_count_ff == '0, "load while busy")
   // A result ends a program and is a single-cycle strobe.
   `SQC_ASSERT_IMPL(a_rsp_ends_run, clock, reset, rsp_valid, $past(busy) && !busy, "stray result")
   `SQC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "repeated result")

endmodule

`default_nettype wire
